/* src/assert_macros.svh */
// Assertion helpers; clk and rst_n must be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/caksc_pkg.sv */
`timescale 1ns / 1ps

package caksc_pkg;

    typedef enum logic [1:0] {
        MODE_SHOW_TIME = 2'd0,
        MODE_SHOW_INFO = 2'd1,
        MODE_SET_DATE  = 2'd2,
        MODE_SET_ALARM = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CMD_ENTER  = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_UP     = 2'd2,
        CMD_RIGHT  = 2'd3
    } cmd_t;

    localparam logic [2:0] CUR_YEAR    = 3'd0;
    localparam logic [2:0] CUR_MONTH   = 3'd1;
    localparam logic [2:0] CUR_DAY     = 3'd2;
    localparam logic [2:0] CUR_WEEKDAY = 3'd3;
    localparam logic [2:0] CUR_HOUR    = 3'd4;
    localparam logic [2:0] CUR_MINUTE  = 3'd5;
    localparam logic [2:0] CUR_SECOND  = 3'd6;
    localparam logic [2:0] CUR_SAVE    = 3'd7;

    localparam logic [2:0] CUR_ALARM_HOUR   = 3'd0;
    localparam logic [2:0] CUR_ALARM_MINUTE = 3'd1;
    localparam logic [2:0] CUR_ALARM_ENABLE = 3'd2;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [1:0]  command;
        logic [55:0] rtc_time_bcd;
    } item_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  cursor;
        logic [6:0]  edit_value;
        logic [4:0]  alarm_hour;
        logic [5:0]  alarm_minute;
        logic        alarm_on;
        logic        rtc_write;
        logic [55:0] save_time_bcd;
    } res_t;

    function automatic logic [6:0] bcd_to_dec(input logic [7:0] b, input logic [6:0] maxv);
        logic [7:0] v;
        v = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'b0000, b[3:0]};
        if (v > {1'b0, maxv})
            return maxv;
        return v[6:0];
    endfunction

    function automatic logic [7:0] dec_to_bcd(input logic [6:0] v);
        logic [14:0] p;
        logic [3:0]  tens;
        logic [6:0]  t10;
        logic [6:0]  r;
        p    = {8'd0, v} * 15'd205;
        tens = p[14:11];
        t10  = {tens, 3'b000} + {2'b00, tens, 1'b0};
        r    = v - t10;
        return {tens, r[3:0]};
    endfunction

    function automatic logic [4:0] day_limit(input logic [3:0] month, input logic [6:0] year);
        if (month == 4'd2 && year[1:0] == 2'b00)
            return 5'd29;
        if (month >= 4'd1 && month <= 4'd12)
            return MONTH_LEN[month - 4'd1];
        return 5'd31;
    endfunction

endpackage

/* src/caksc_input_stage.sv */
`timescale 1ns / 1ps

module caksc_input_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           command,
    input  logic [55:0]          rtc_time_bcd,
    input  logic                 advance,
    output logic                 item_valid,
    output caksc_pkg::item_t     item
);

    logic             valid_reg;
    logic             valid_next;
    caksc_pkg::item_t item_reg;
    logic             load;

    assign load     = !valid_reg || advance;
    assign in_stall = !load;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            item_reg.command      <= command;
            item_reg.rtc_time_bcd <= rtc_time_bcd;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* src/caksc_core.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module caksc_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              commit,
    input  caksc_pkg::item_t  item,
    output caksc_pkg::res_t   res
);

    caksc_pkg::mode_t mode_reg, mode_next;
    logic [2:0] cursor_reg, cursor_next;
    logic [6:0] year_reg, year_next;
    logic [3:0] month_reg, month_next;
    logic [4:0] day_reg, day_next;
    logic [2:0] weekday_reg, weekday_next;
    logic [4:0] hour_reg, hour_next;
    logic [5:0] minute_reg, minute_next;
    logic [5:0] second_reg, second_next;
    logic [4:0] alarm_hour_reg, alarm_hour_next;
    logic [5:0] alarm_minute_reg, alarm_minute_next;
    logic       alarm_on_reg, alarm_on_next;

    logic [7:0] year_inc;
    logic [4:0] month_inc;
    logic [5:0] day_inc;
    logic [3:0] weekday_inc;
    logic [5:0] hour_inc;
    logic [6:0] minute_inc;
    logic [6:0] second_inc;
    logic [5:0] alarm_hour_inc;
    logic [6:0] alarm_minute_inc;
    logic [2:0] cursor_inc;
    logic [7:0] week_byte;
    logic       wr;
    logic [6:0] ev;

    assign year_inc         = {1'b0, year_reg} + 8'd1;
    assign month_inc        = {1'b0, month_reg} + 5'd1;
    assign day_inc          = {1'b0, day_reg} + 6'd1;
    assign weekday_inc      = {1'b0, weekday_reg} + 4'd1;
    assign hour_inc         = {1'b0, hour_reg} + 6'd1;
    assign minute_inc       = {1'b0, minute_reg} + 7'd1;
    assign second_inc       = {1'b0, second_reg} + 7'd1;
    assign alarm_hour_inc   = {1'b0, alarm_hour_reg} + 6'd1;
    assign alarm_minute_inc = {1'b0, alarm_minute_reg} + 7'd1;
    assign cursor_inc       = cursor_reg + 3'd1;
    assign week_byte        = item.rtc_time_bcd[47:40];

    always_comb
    begin
        mode_next         = mode_reg;
        cursor_next       = cursor_reg;
        year_next         = year_reg;
        month_next        = month_reg;
        day_next          = day_reg;
        weekday_next      = weekday_reg;
        hour_next         = hour_reg;
        minute_next       = minute_reg;
        second_next       = second_reg;
        alarm_hour_next   = alarm_hour_reg;
        alarm_minute_next = alarm_minute_reg;
        alarm_on_next     = alarm_on_reg;
        wr                = 1'b0;
        case (caksc_pkg::cmd_t'(item.command))
            caksc_pkg::CMD_ENTER:
            begin
                if (mode_reg == caksc_pkg::MODE_SET_DATE)
                begin
                    mode_next = caksc_pkg::MODE_SET_ALARM;
                end
                else
                begin
                    mode_next    = caksc_pkg::MODE_SET_DATE;
                    second_next  = 6'(caksc_pkg::bcd_to_dec(item.rtc_time_bcd[7:0], 7'd63));
                    minute_next  = 6'(caksc_pkg::bcd_to_dec(item.rtc_time_bcd[15:8], 7'd63));
                    hour_next    = 5'(caksc_pkg::bcd_to_dec(item.rtc_time_bcd[23:16], 7'd31));
                    day_next     = 5'(caksc_pkg::bcd_to_dec(item.rtc_time_bcd[31:24], 7'd31));
                    month_next   = 4'(caksc_pkg::bcd_to_dec(item.rtc_time_bcd[39:32], 7'd15));
                    weekday_next = (week_byte > 8'd7) ? 3'd7 : week_byte[2:0];
                    year_next    = caksc_pkg::bcd_to_dec(item.rtc_time_bcd[55:48], 7'd127);
                end
                cursor_next = 3'd0;
            end
            caksc_pkg::CMD_CANCEL:
            begin
                mode_next = caksc_pkg::MODE_SHOW_TIME;
            end
            caksc_pkg::CMD_UP:
            begin
                if (mode_reg == caksc_pkg::MODE_SET_DATE)
                begin
                    case (cursor_reg)
                        caksc_pkg::CUR_YEAR:
                            year_next = (year_inc > 8'd99) ? 7'd0 : year_inc[6:0];
                        caksc_pkg::CUR_MONTH:
                            month_next = (month_inc > 5'd12) ? 4'd1 : month_inc[3:0];
                        caksc_pkg::CUR_DAY:
                            day_next = (day_inc > {1'b0, caksc_pkg::day_limit(month_reg,
                                       year_reg)}) ? 5'd1 : day_inc[4:0];
                        caksc_pkg::CUR_WEEKDAY:
                            weekday_next = (weekday_inc > 4'd7) ? 3'd1 : weekday_inc[2:0];
                        caksc_pkg::CUR_HOUR:
                            hour_next = (hour_inc > 6'd23) ? 5'd0 : hour_inc[4:0];
                        caksc_pkg::CUR_MINUTE:
                            minute_next = (minute_inc > 7'd59) ? 6'd0 : minute_inc[5:0];
                        caksc_pkg::CUR_SECOND:
                            second_next = (second_inc > 7'd59) ? 6'd0 : second_inc[5:0];
                        default:
                            wr = 1'b1;
                    endcase
                end
                else if (mode_reg == caksc_pkg::MODE_SET_ALARM)
                begin
                    case (cursor_reg)
                        caksc_pkg::CUR_ALARM_HOUR:
                            alarm_hour_next = (alarm_hour_inc > 6'd23) ? 5'd0
                                              : alarm_hour_inc[4:0];
                        caksc_pkg::CUR_ALARM_MINUTE:
                            alarm_minute_next = (alarm_minute_inc > 7'd59) ? 6'd0
                                                : alarm_minute_inc[5:0];
                        caksc_pkg::CUR_ALARM_ENABLE:
                            alarm_on_next = !alarm_on_reg;
                        default:
                            alarm_on_next = alarm_on_reg;
                    endcase
                end
            end
            default:
            begin
                if (mode_reg == caksc_pkg::MODE_SHOW_TIME)
                    mode_next = caksc_pkg::MODE_SHOW_INFO;
                else if (mode_reg == caksc_pkg::MODE_SHOW_INFO)
                    mode_next = caksc_pkg::MODE_SHOW_TIME;
                else if (mode_reg == caksc_pkg::MODE_SET_DATE)
                    cursor_next = cursor_inc;
                else
                    cursor_next = (cursor_inc > caksc_pkg::CUR_ALARM_ENABLE) ? 3'd0
                                  : cursor_inc;
            end
        endcase
    end

    always_comb
    begin
        ev = 7'd0;
        if (mode_next == caksc_pkg::MODE_SET_DATE)
        begin
            case (cursor_next)
                caksc_pkg::CUR_YEAR:    ev = year_next;
                caksc_pkg::CUR_MONTH:   ev = {3'd0, month_next};
                caksc_pkg::CUR_DAY:     ev = {2'd0, day_next};
                caksc_pkg::CUR_WEEKDAY: ev = {4'd0, weekday_next};
                caksc_pkg::CUR_HOUR:    ev = {2'd0, hour_next};
                caksc_pkg::CUR_MINUTE:  ev = {1'd0, minute_next};
                caksc_pkg::CUR_SECOND:  ev = {1'd0, second_next};
                default:                ev = 7'd0;
            endcase
        end
        else if (mode_next == caksc_pkg::MODE_SET_ALARM)
        begin
            case (cursor_next)
                caksc_pkg::CUR_ALARM_HOUR:   ev = {2'd0, alarm_hour_next};
                caksc_pkg::CUR_ALARM_MINUTE: ev = {1'd0, alarm_minute_next};
                caksc_pkg::CUR_ALARM_ENABLE: ev = {6'd0, alarm_on_next};
                default:                     ev = 7'd0;
            endcase
        end
    end

    always_comb
    begin
        res.mode          = mode_next;
        res.cursor        = cursor_next;
        res.edit_value    = ev;
        res.alarm_hour    = alarm_hour_next;
        res.alarm_minute  = alarm_minute_next;
        res.alarm_on      = alarm_on_next;
        res.rtc_write     = wr;
        res.save_time_bcd = 56'd0;
        if (wr)
        begin
            res.save_time_bcd = {caksc_pkg::dec_to_bcd(year_reg),
                                 caksc_pkg::dec_to_bcd({4'd0, weekday_reg}),
                                 caksc_pkg::dec_to_bcd({3'd0, month_reg}),
                                 caksc_pkg::dec_to_bcd({2'd0, day_reg}),
                                 caksc_pkg::dec_to_bcd({2'd0, hour_reg}),
                                 caksc_pkg::dec_to_bcd({1'd0, minute_reg}),
                                 caksc_pkg::dec_to_bcd({1'd0, second_reg})};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= caksc_pkg::MODE_SHOW_TIME;
            cursor_reg       <= 3'd0;
            year_reg         <= 7'd0;
            month_reg        <= 4'd0;
            day_reg          <= 5'd0;
            weekday_reg      <= 3'd0;
            hour_reg         <= 5'd0;
            minute_reg       <= 6'd0;
            second_reg       <= 6'd0;
            alarm_hour_reg   <= 5'd0;
            alarm_minute_reg <= 6'd0;
            alarm_on_reg     <= 1'b0;
        end
        else if (commit)
        begin
            mode_reg         <= mode_next;
            cursor_reg       <= cursor_next;
            year_reg         <= year_next;
            month_reg        <= month_next;
            day_reg          <= day_next;
            weekday_reg      <= weekday_next;
            hour_reg         <= hour_next;
            minute_reg       <= minute_next;
            second_reg       <= second_next;
            alarm_hour_reg   <= alarm_hour_next;
            alarm_minute_reg <= alarm_minute_next;
            alarm_on_reg     <= alarm_on_next;
        end
    end

    `ASSERT_IMPL(a_alarm_range, 1'b1, alarm_hour_reg <= 5'd23 && alarm_minute_reg <= 6'd59,
                 "alarm store out of range")
    `ASSERT_IMPL(a_alarm_cursor, mode_reg == caksc_pkg::MODE_SET_ALARM,
                 cursor_reg <= caksc_pkg::CUR_ALARM_ENABLE, "alarm cursor out of range")
    `ASSERT_NEXT(a_hold_state, !commit, $stable(mode_reg) && $stable(cursor_reg),
                 "state moved without a transaction")

endmodule

/* src/clock_alarm_key_setting_controller.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// channel | handshake            | payload
// input   | in_valid / in_stall   | command, rtc_time_bcd
// output  | out_valid / out_stall | mode, cursor, edit_value, alarm_hour, alarm_minute,
//         |                       | alarm_on, rtc_write, save_time_bcd
// One transaction per cycle sustained while out_stall is low.
// The path is an input register, then the key decode and field update into the result register.
// rst_n clears mode, cursor, edit buffer, alarm store and both valid flags.
// A stalled result holds; the input register keeps filling until it is also full.

module clock_alarm_key_setting_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [55:0] rtc_time_bcd,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  mode,
    output logic [2:0]  cursor,
    output logic [6:0]  edit_value,
    output logic [4:0]  alarm_hour,
    output logic [5:0]  alarm_minute,
    output logic        alarm_on,
    output logic        rtc_write,
    output logic [55:0] save_time_bcd
);

    caksc_pkg::item_t item;
    caksc_pkg::res_t  res;
    caksc_pkg::res_t  res_reg;
    logic             item_valid;
    logic             advance;
    logic             commit;
    logic             out_valid_reg;
    logic             out_valid_next;

    assign advance = !out_valid_reg || !out_stall;
    assign commit  = item_valid && advance;

    caksc_input_stage u_input_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .rtc_time_bcd (rtc_time_bcd),
        .advance      (advance),
        .item_valid   (item_valid),
        .item         (item)
    );

    caksc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (commit),
        .item   (item),
        .res    (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign mode          = res_reg.mode;
    assign cursor        = res_reg.cursor;
    assign edit_value    = res_reg.edit_value;
    assign alarm_hour    = res_reg.alarm_hour;
    assign alarm_minute  = res_reg.alarm_minute;
    assign alarm_on      = res_reg.alarm_on;
    assign rtc_write     = res_reg.rtc_write;
    assign save_time_bcd = res_reg.save_time_bcd;

    `ASSERT_IMPL(a_write_at_save, out_valid_reg && res_reg.rtc_write,
                 res_reg.mode == caksc_pkg::MODE_SET_DATE && res_reg.cursor == caksc_pkg::CUR_SAVE,
                 "rtc write outside the save cursor")
    `ASSERT_IMPL(a_save_zero, out_valid_reg && !res_reg.rtc_write,
                 res_reg.save_time_bcd == 56'd0, "save time without rtc write")
    `ASSERT_IMPL(a_stall_cause, in_stall, out_valid_reg && out_stall && item_valid,
                 "input stalled with room downstream")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import caksc_pkg::*;

    localparam int RANDOM_KEYS   = 500;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int LONG_HOLD     = 80;
    localparam int REPORT_CAP    = 40;
    localparam int DIRECTED_ROWS = 28;

    typedef struct packed {
        cmd_t        key;
        logic [55:0] rtc;
        logic        typed;
        mode_t       mode;
        logic [2:0]  cursor;
        logic [6:0]  value;
    } key_row_t;

    localparam key_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{CMD_UP,     56'h00_0000_0000_0000, 1'b1, MODE_SHOW_TIME, CUR_YEAR, 7'd0},
        '{CMD_RIGHT,  56'h55_5555_5555_5555, 1'b1, MODE_SHOW_INFO, CUR_YEAR, 7'd0},
        '{CMD_CANCEL, 56'hAA_AAAA_AAAA_AAAA, 1'b1, MODE_SHOW_TIME, CUR_YEAR, 7'd0},
        '{CMD_ENTER,  56'hFF_FFFF_FFFF_FFFF, 1'b1, MODE_SET_DATE,  CUR_YEAR, 7'd127},
        '{CMD_UP,     56'h00_0000_0000_0000, 1'b0, MODE_SHOW_TIME, CUR_YEAR, 7'd0},
        '{CMD_RIGHT,  56'h00_0000_0000_0000, 1'b0, MODE_SHOW_TIME, CUR_YEAR, 7'd0},
        '{CMD_UP,     56'h00_0000_0000_0000, 1'b0, MODE_SHOW_TIME, CUR_YEAR, 7'd0},
        '{CMD_RIGHT,  56'h00_0000_0000_0000, 1'b0, MODE_SHOW_TIME, CUR_YEAR, 7'd0},
        '{CMD_UP,     56'h00_0000_0000_0000, 1'b0, MODE_SHOW_TIME, CUR_YEAR, 7'd0},
        '{CMD_RIGHT,  56'h00_0000_0000_0000, 1'b0, MODE_SHOW_TIME, CUR_YEAR, 7'd0},
        '{CMD_UP,     56'h00_0000_0000_0000, 1'b0, MODE_SHOW_TIME, CUR_YEAR, 7'd0},
        '{CMD_RIGHT,  56'h00_0000_0000_0000, 1'b0, MODE_SHOW_TIME, CUR_YEAR, 7'd0},
        '{CMD_UP,     56'h00_0000_0000_0000, 1'b0, MODE_SHOW_TIME, CUR_YEAR, 7'd0},
        '{CMD_RIGHT,  56'h00_0000_0000_0000, 1'b0, MODE_SHOW_TIME, CUR_YEAR, 7'd0},
        '{CMD_UP,     56'h00_0000_0000_0000, 1'b0, MODE_SHOW_TIME, CUR_YEAR, 7'd0},
        '{CMD_RIGHT,  56'h00_0000_0000_0000, 1'b0, MODE_SHOW_TIME, CUR_YEAR, 7'd0},
        '{CMD_UP,     56'h00_0000_0000_0000, 1'b0, MODE_SHOW_TIME, CUR_YEAR, 7'd0},
        '{CMD_RIGHT,  56'h00_0000_0000_0000, 1'b0, MODE_SHOW_TIME, CUR_YEAR, 7'd0},
        '{CMD_UP,     56'h00_0000_0000_0000, 1'b0, MODE_SHOW_TIME, CUR_YEAR, 7'd0},
        '{CMD_RIGHT,  56'h00_0000_0000_0000, 1'b0, MODE_SHOW_TIME, CUR_YEAR, 7'd0},
        '{CMD_ENTER,  56'h12_3456_7890_1234, 1'b1, MODE_SET_ALARM, CUR_ALARM_HOUR, 7'd0},
        '{CMD_UP,     56'h00_0000_0000_0000, 1'b0, MODE_SHOW_TIME, CUR_YEAR, 7'd0},
        '{CMD_RIGHT,  56'h00_0000_0000_0000, 1'b0, MODE_SHOW_TIME, CUR_YEAR, 7'd0},
        '{CMD_RIGHT,  56'h00_0000_0000_0000, 1'b0, MODE_SHOW_TIME, CUR_YEAR, 7'd0},
        '{CMD_UP,     56'h00_0000_0000_0000, 1'b0, MODE_SHOW_TIME, CUR_YEAR, 7'd0},
        '{CMD_RIGHT,  56'h00_0000_0000_0000, 1'b0, MODE_SHOW_TIME, CUR_YEAR, 7'd0},
        '{CMD_ENTER,  56'h00_0000_0000_0000, 1'b0, MODE_SHOW_TIME, CUR_YEAR, 7'd0},
        '{CMD_CANCEL, 56'hFF_FFFF_FFFF_FFFF, 1'b0, MODE_SHOW_TIME, CUR_YEAR, 7'd0}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    cmd_t        command;
    logic [55:0] rtc_time_bcd;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  mode;
    logic [2:0]  cursor;
    logic [6:0]  edit_value;
    logic [4:0]  alarm_hour;
    logic [5:0]  alarm_minute;
    logic        alarm_on;
    logic        rtc_write;
    logic [55:0] save_time_bcd;

    logic        row_typed;
    res_t        row_want;

    res_t        panel_expected [$];
    int          keys_sent;
    int          results_seen;
    int          saves_seen;
    int          errors;
    int          cycle_count;

    mode_t       ui_now    = MODE_SHOW_TIME;
    logic [2:0]  cur_now   = 3'd0;
    logic [6:0]  ed_year   = '0;
    logic [3:0]  ed_month  = '0;
    logic [4:0]  ed_day    = '0;
    logic [2:0]  ed_wday   = '0;
    logic [4:0]  ed_hour   = '0;
    logic [5:0]  ed_minute = '0;
    logic [5:0]  ed_second = '0;
    logic [4:0]  al_hour   = '0;
    logic [5:0]  al_minute = '0;
    logic        al_on     = 1'b0;

    clock_alarm_key_setting_controller DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .rtc_time_bcd  (rtc_time_bcd),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .mode          (mode),
        .cursor        (cursor),
        .edit_value    (edit_value),
        .alarm_hour    (alarm_hour),
        .alarm_minute  (alarm_minute),
        .alarm_on      (alarm_on),
        .rtc_write     (rtc_write),
        .save_time_bcd (save_time_bcd)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int bcd_value(input logic [7:0] b, input int maxv);
        int v;
        v = int'(b[7:4]) * 10 + int'(b[3:0]);
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic logic [7:0] pack_bcd(input int v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    function automatic int bump(input int v, input int top, input int floor_value);
        return (v + 1 > top) ? floor_value : v + 1;
    endfunction

    function automatic int month_days();
        if (ed_month == 4'd2 && (ed_year % 4) == 0)
            return 29;
        case (ed_month)
            4'd2:                      return 28;
            4'd4, 4'd6, 4'd9, 4'd11:   return 30;
            default:                   return 31;
        endcase
    endfunction

    function automatic res_t apply_key(input cmd_t key, input logic [55:0] t);
        res_t r;
        r = '0;
        case (key)
            CMD_ENTER:
            begin
                if (ui_now == MODE_SET_DATE)
                    ui_now = MODE_SET_ALARM;
                else
                begin
                    ui_now    = MODE_SET_DATE;
                    ed_second = 6'(bcd_value(t[7:0], 63));
                    ed_minute = 6'(bcd_value(t[15:8], 63));
                    ed_hour   = 5'(bcd_value(t[23:16], 31));
                    ed_day    = 5'(bcd_value(t[31:24], 31));
                    ed_month  = 4'(bcd_value(t[39:32], 15));
                    ed_wday   = (t[47:40] > 8'd7) ? 3'd7 : t[42:40];
                    ed_year   = 7'(bcd_value(t[55:48], 127));
                end
                cur_now = 3'd0;
            end
            CMD_CANCEL:
                ui_now = MODE_SHOW_TIME;
            CMD_UP:
            begin
                if (ui_now == MODE_SET_DATE)
                begin
                    case (cur_now)
                        CUR_YEAR:    ed_year   = 7'(bump(ed_year, 99, 0));
                        CUR_MONTH:   ed_month  = 4'(bump(ed_month, 12, 1));
                        CUR_DAY:     ed_day    = 5'(bump(ed_day, month_days(), 1));
                        CUR_WEEKDAY: ed_wday   = 3'(bump(ed_wday, 7, 1));
                        CUR_HOUR:    ed_hour   = 5'(bump(ed_hour, 23, 0));
                        CUR_MINUTE:  ed_minute = 6'(bump(ed_minute, 59, 0));
                        CUR_SECOND:  ed_second = 6'(bump(ed_second, 59, 0));
                        default:
                        begin
                            r.rtc_write     = 1'b1;
                            r.save_time_bcd = {pack_bcd(ed_year), pack_bcd(ed_wday),
                                               pack_bcd(ed_month), pack_bcd(ed_day),
                                               pack_bcd(ed_hour), pack_bcd(ed_minute),
                                               pack_bcd(ed_second)};
                        end
                    endcase
                end
                else if (ui_now == MODE_SET_ALARM)
                begin
                    case (cur_now)
                        CUR_ALARM_HOUR:   al_hour   = 5'(bump(al_hour, 23, 0));
                        CUR_ALARM_MINUTE: al_minute = 6'(bump(al_minute, 59, 0));
                        CUR_ALARM_ENABLE: al_on     = ~al_on;
                        default:          ;
                    endcase
                end
            end
            default:
            begin
                if (ui_now == MODE_SHOW_TIME)
                    ui_now = MODE_SHOW_INFO;
                else if (ui_now == MODE_SHOW_INFO)
                    ui_now = MODE_SHOW_TIME;
                else if (ui_now == MODE_SET_DATE)
                    cur_now = cur_now + 3'd1;
                else
                    cur_now = (cur_now >= CUR_ALARM_ENABLE) ? CUR_ALARM_HOUR
                                                            : cur_now + 3'd1;
            end
        endcase

        if (ui_now == MODE_SET_DATE)
        begin
            case (cur_now)
                CUR_YEAR:    r.edit_value = ed_year;
                CUR_MONTH:   r.edit_value = 7'(ed_month);
                CUR_DAY:     r.edit_value = 7'(ed_day);
                CUR_WEEKDAY: r.edit_value = 7'(ed_wday);
                CUR_HOUR:    r.edit_value = 7'(ed_hour);
                CUR_MINUTE:  r.edit_value = 7'(ed_minute);
                CUR_SECOND:  r.edit_value = 7'(ed_second);
                default:     r.edit_value = 7'd0;
            endcase
        end
        else if (ui_now == MODE_SET_ALARM)
        begin
            case (cur_now)
                CUR_ALARM_HOUR:   r.edit_value = 7'(al_hour);
                CUR_ALARM_MINUTE: r.edit_value = 7'(al_minute);
                CUR_ALARM_ENABLE: r.edit_value = 7'(al_on);
                default:          r.edit_value = 7'd0;
            endcase
        end

        r.mode         = ui_now;
        r.cursor       = cur_now;
        r.alarm_hour   = al_hour;
        r.alarm_minute = al_minute;
        r.alarm_on     = al_on;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        if (errors <= REPORT_CAP)
            $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
    endtask

    function automatic int near_top(input int lo, input int hi, input int span);
        return ($urandom_range(0, 1) != 0) ? $urandom_range(hi - span, hi)
                                          : $urandom_range(lo, hi);
    endfunction

    function automatic logic [55:0] random_rtc();
        logic [63:0] raw;
        int          mon;
        raw = {$urandom, $urandom};
        if ($urandom_range(0, 4) == 0)
            return raw[55:0];
        mon = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(1, 12);
        return {pack_bcd(near_top(0, 99, 4)), 8'($urandom_range(0, 7)),
                pack_bcd(mon), pack_bcd(near_top(1, 31, 5)),
                pack_bcd(near_top(0, 23, 3)), pack_bcd(near_top(0, 59, 4)),
                pack_bcd(near_top(0, 59, 4))};
    endfunction

    task automatic offer_key(input cmd_t key, input logic [55:0] t, input logic typed,
                             input res_t want);
        int gap;
        gap = ((keys_sent / 50) % 4 == 3) ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= key;
        rtc_time_bcd <= t;
        row_typed    <= typed;
        row_want     <= want;
        do @(posedge clk); while (in_stall);
        keys_sent++;
    endtask

    task automatic offer_random(input cmd_t key);
        offer_key(key, random_rtc(), 1'b0, '0);
    endtask

    task automatic play_random_burst();
        int scene;
        int k;
        int n;
        scene = $urandom_range(0, 9);
        if (scene < 4)
        begin
            offer_random(CMD_CANCEL);
            offer_random(CMD_ENTER);
            k = $urandom_range(0, 7);
            repeat (k) offer_random(CMD_RIGHT);
            n = $urandom_range(1, 8);
            repeat (n) offer_random(CMD_UP);
            if ($urandom_range(0, 1) != 0)
            begin
                repeat (7 - k) offer_random(CMD_RIGHT);
                offer_random(CMD_UP);
            end
        end
        else if (scene < 7)
        begin
            offer_random(CMD_CANCEL);
            offer_random(CMD_ENTER);
            offer_random(CMD_ENTER);
            k = $urandom_range(0, 3);
            repeat (k) offer_random(CMD_RIGHT);
            n = $urandom_range(1, 30);
            repeat (n) offer_random(CMD_UP);
        end
        else if (scene < 9)
        begin
            n = $urandom_range(1, 6);
            repeat (n) offer_random(cmd_t'($urandom_range(0, 3)));
        end
        else
        begin
            offer_random(CMD_CANCEL);
            n = $urandom_range(1, 4);
            repeat (n) offer_random(CMD_RIGHT);
        end
    endtask

    // hold results back now and then, with two long hold-offs to fill the block
    initial
    begin
        int hold;
        int drawn;
        drawn = 0;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (drawn == 100 || drawn == 350)
                hold = LONG_HOLD;
            else if ((drawn / 40) % 3 == 2)
                hold = 0;
            else
                hold = $urandom_range(0, 13);
            drawn++;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        res_t p;
        if (rst_n && in_valid && !in_stall)
        begin
            p = apply_key(command, rtc_time_bcd);
            panel_expected.push_back(row_typed ? row_want : p);
        end
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (rtc_write === 1'b1)
                saves_seen++;
            if (panel_expected.size() == 0)
                report_mismatch("result with no transaction pending", '0, '0);
            else
            begin
                want = panel_expected.pop_front();
                if (mode !== want.mode)
                    report_mismatch("mode", mode, want.mode);
                if (cursor !== want.cursor)
                    report_mismatch("cursor", cursor, want.cursor);
                if (edit_value !== want.edit_value)
                    report_mismatch("edit_value", edit_value, want.edit_value);
                if (alarm_hour !== want.alarm_hour)
                    report_mismatch("alarm_hour", alarm_hour, want.alarm_hour);
                if (alarm_minute !== want.alarm_minute)
                    report_mismatch("alarm_minute", alarm_minute, want.alarm_minute);
                if (alarm_on !== want.alarm_on)
                    report_mismatch("alarm_on", alarm_on, want.alarm_on);
                if (rtc_write !== want.rtc_write)
                    report_mismatch("rtc_write", rtc_write, want.rtc_write);
                if (save_time_bcd !== want.save_time_bcd)
                    report_mismatch("save_time_bcd", save_time_bcd, want.save_time_bcd);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        res_t want;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        command      <= CMD_ENTER;
        rtc_time_bcd <= '0;
        row_typed    <= 1'b0;
        row_want     <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            want            = '0;
            want.mode       = DIRECTED[i].mode;
            want.cursor     = DIRECTED[i].cursor;
            want.edit_value = DIRECTED[i].value;
            offer_key(DIRECTED[i].key, DIRECTED[i].rtc, DIRECTED[i].typed, want);
        end

        while (keys_sent < DIRECTED_ROWS + RANDOM_KEYS)
            play_random_burst();
        in_valid <= 1'b0;

        wait (panel_expected.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d key transactions and %0d checked results, %0d RTC saves,",
                 keys_sent, results_seen, saves_seen);
        $display("with %0d mismatches in %0d cycles.", errors, cycle_count);
        if (errors == 0 && panel_expected.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
